[sv/nnds_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest-neighbor downscaler package
// Shared widths, register indexes, divider states and the result record.
// ----------------------------------------------------------------------------
package nnds_pkg;

  localparam int DIM_W   = 13;
  localparam int SUM_W   = 25;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int NUM_CH  = 4;
  localparam int CC_W    = 3;
  localparam int IDX_W   = 2;
  localparam int MAX_DIM = 4096;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_WIDTH     = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN
  } div_state_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] pix;
    logic [COORD_W-1:0]           x;
    logic [COORD_W-1:0]           y;
    logic                         last;
  } result_t;

endpackage

[sv/nearest_neighbor_downscaler.sv]
// ----------------------------------------------------------------------------
// Nearest-neighbor downscaler
// Keeps the source pixels picked by an aspect-preserving nearest-neighbor
// reduction to at most max_width columns and tags each with its output position.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock in raster order, unless stalled, and decides in
// the same cycle whether it is kept, using running sums compared against each
// other. Results go into a two-entry output queue, so a new pixel is taken
// while one result waits to be taken. Every register write restarts the frame
// and recomputes the output height with a shift-subtract divider: after a write
// the input is stalled through the multiply state and 26 divide steps.
// Configuration writes are always taken.
module nearest_neighbor_downscaler #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nnds_pkg::IDX_W-1:0]          cfg_index,
  input  logic [nnds_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nnds_pkg::PIX_W-1:0]          chan0,
  input  logic [nnds_pkg::PIX_W-1:0]          chan1,
  input  logic [nnds_pkg::PIX_W-1:0]          chan2,
  input  logic [nnds_pkg::PIX_W-1:0]          chan3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nnds_pkg::PIX_W-1:0]          pix0,
  output logic [nnds_pkg::PIX_W-1:0]          pix1,
  output logic [nnds_pkg::PIX_W-1:0]          pix2,
  output logic [nnds_pkg::PIX_W-1:0]          pix3,
  output logic [nnds_pkg::COORD_W-1:0]        out_x,
  output logic [nnds_pkg::COORD_W-1:0]        out_y,
  output logic                                frame_end
);
  import nnds_pkg::*;

  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic [DIM_W-1:0] source_width, source_height, max_width;
  logic [CC_W-1:0]  channel_count;

  logic [DIM_W-1:0] in_column, in_row, next_out_column, next_out_row;
  logic [SUM_W-1:0] column_target_sum, column_position_sum;
  logic [SUM_W-1:0] row_target_sum, row_position_sum;
  logic [DIM_W-1:0] output_height;

  logic [DIM_W-1:0] in_column_next, in_row_next, next_out_column_next, next_out_row_next;
  logic [SUM_W-1:0] column_target_sum_next, column_position_sum_next;
  logic [SUM_W-1:0] row_target_sum_next, row_position_sum_next;

  div_state_t        div_state, div_state_next;
  logic [DIM_W-1:0]  div_rem;
  logic [PROD_W-1:0] div_quo;
  logic [CNT_W-1:0]  div_cnt;
  logic [DIM_W:0]    div_shifted, div_diff;
  logic              div_ge;
  logic              div_load, div_step, div_last;

  result_t    slot0, slot1, res;
  logic [1:0] fifo_count;
  logic       cfg_wr, accept, pop, push, emit;

  logic [CC_W-1:0]  cc;
  logic             frame_ok, start, row_end, frame_last, row_hit, col_hit;
  logic [DIM_W-1:0] noc, nro;
  logic [SUM_W-1:0] cts, cps, rts, rps;
  logic [NUM_CH-1:0][PIX_W-1:0] chan_in;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = (div_state != DIV_IDLE) | (fifo_count == 2'd2);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = (fifo_count != 2'd0);
  assign pop       = out_valid & ~out_stall;
  assign push      = accept & emit;

  assign pix0      = slot0.pix[0];
  assign pix1      = slot0.pix[1];
  assign pix2      = slot0.pix[2];
  assign pix3      = slot0.pix[3];
  assign out_x     = slot0.x;
  assign out_y     = slot0.y;
  assign frame_end = slot0.last;

  assign chan_in = {chan3, chan2, chan1, chan0};

  always_comb begin
    cc = (int'(channel_count) > MAX_CHANNELS) ? CC_W'(MAX_CHANNELS) : channel_count;
    frame_ok = (source_width != '0) && (source_height != '0) && (cc != '0);
    start = (in_column == '0) && (in_row == '0);
    noc = start ? '0 : next_out_column;
    nro = start ? '0 : next_out_row;
    cts = start ? '0 : column_target_sum;
    cps = start ? '0 : column_position_sum;
    rts = start ? '0 : row_target_sum;
    rps = start ? '0 : row_position_sum;

    row_end    = ({1'b0, in_column} + 1'b1) >= {1'b0, source_width};
    frame_last = row_end && (({1'b0, in_row} + 1'b1) >= {1'b0, source_height});

    row_hit = (nro < output_height) &&
              ({1'b0, rts} < ({1'b0, rps} + (SUM_W + 1)'(output_height)));
    col_hit = (noc < max_width) &&
              ({1'b0, cts} < ({1'b0, cps} + (SUM_W + 1)'(max_width)));

    for (int i = 0; i < NUM_CH; i++) begin
      res.pix[i] = (i < int'(cc)) ? chan_in[i] : '0;
    end
    res.x    = '0;
    res.y    = '0;
    res.last = 1'b0;
    emit     = 1'b1;

    in_column_next           = in_column;
    in_row_next              = in_row;
    next_out_column_next     = next_out_column;
    next_out_row_next        = next_out_row;
    column_target_sum_next   = column_target_sum;
    column_position_sum_next = column_position_sum;
    row_target_sum_next      = row_target_sum;
    row_position_sum_next    = row_position_sum;

    if (frame_ok) begin
      next_out_column_next     = noc;
      next_out_row_next        = nro;
      column_target_sum_next   = cts;
      column_position_sum_next = cps;
      row_target_sum_next      = rts;
      row_position_sum_next    = rps;
      if (source_width <= max_width) begin
        res.x    = in_column[COORD_W-1:0];
        res.y    = in_row[COORD_W-1:0];
        res.last = frame_last;
      end else begin
        emit = row_hit && col_hit;
        res.x    = noc[COORD_W-1:0];
        res.y    = nro[COORD_W-1:0];
        res.last = (({1'b0, noc} + 1'b1) == {1'b0, max_width}) &&
                   (({1'b0, nro} + 1'b1) == {1'b0, output_height});
        if (col_hit) begin
          next_out_column_next   = noc + 1'b1;
          column_target_sum_next = cts + SUM_W'(source_width);
        end
        column_position_sum_next = cps + SUM_W'(max_width);
        if (row_end) begin
          next_out_column_next     = '0;
          column_target_sum_next   = '0;
          column_position_sum_next = '0;
          if (row_hit) begin
            next_out_row_next   = nro + 1'b1;
            row_target_sum_next = rts + SUM_W'(source_height);
          end
          row_position_sum_next = rps + SUM_W'(output_height);
        end
      end
      if (row_end) begin
        in_column_next = '0;
        in_row_next    = frame_last ? '0 : in_row + 1'b1;
      end else begin
        in_column_next = in_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width        <= '0;
      source_height       <= '0;
      channel_count       <= CC_W'(3);
      max_width           <= clamp_dim(DIM_W'(320));
      in_column           <= '0;
      in_row              <= '0;
      next_out_column     <= '0;
      next_out_row        <= '0;
      column_target_sum   <= '0;
      column_position_sum <= '0;
      row_target_sum      <= '0;
      row_position_sum    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= clamp_dim(cfg_data);
        REG_SOURCE_HEIGHT: source_height <= clamp_dim(cfg_data);
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
        REG_MAX_WIDTH:     max_width     <= clamp_dim(cfg_data);
        default:           ;
      endcase
      in_column           <= '0;
      in_row              <= '0;
      next_out_column     <= '0;
      next_out_row        <= '0;
      column_target_sum   <= '0;
      column_position_sum <= '0;
      row_target_sum      <= '0;
      row_position_sum    <= '0;
    end else if (accept) begin
      in_column           <= in_column_next;
      in_row              <= in_row_next;
      next_out_column     <= next_out_column_next;
      next_out_row        <= next_out_row_next;
      column_target_sum   <= column_target_sum_next;
      column_position_sum <= column_position_sum_next;
      row_target_sum      <= row_target_sum_next;
      row_position_sum    <= row_position_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count <= '0;
    end else begin
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && fifo_count == 2'd2) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (fifo_count == 2'd0 || (fifo_count == 2'd1 && pop)) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  always_comb begin
    div_shifted = {div_rem, div_quo[PROD_W-1]};
    div_ge      = div_shifted >= {1'b0, source_width};
    div_diff    = div_shifted - {1'b0, source_width};
    div_last    = (div_cnt == CNT_W'(DIV_STEPS - 1));
  end

  always_comb begin
    div_state_next = div_state;
    div_load       = 1'b0;
    div_step       = 1'b0;
    if (cfg_wr) begin
      div_state_next = DIV_MUL;
    end else begin
      unique case (div_state)
        DIV_IDLE: ;
        DIV_MUL: begin
          div_load       = 1'b1;
          div_state_next = DIV_RUN;
        end
        DIV_RUN: begin
          div_step = 1'b1;
          if (div_last) begin
            div_state_next = DIV_IDLE;
          end
        end
        default: div_state_next = DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
    end else begin
      div_state <= div_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_height <= '0;
    end else if (div_step && div_last) begin
      output_height <= {div_quo[DIM_W-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_quo <= PROD_W'(source_height) * PROD_W'(max_width);
      div_rem <= '0;
      div_cnt <= '0;
    end else if (div_step) begin
      div_quo <= {div_quo[PROD_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[DIM_W-1:0] : div_shifted[DIM_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> in_stall)
    else $error("input not stalled after a register write");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (source_height != '0) |-> (in_row < source_height))
    else $error("raster row outside the source frame");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    (source_width != '0) |-> (in_column < source_width))
    else $error("raster column outside the source row");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count != 2'd3)
    else $error("output queue overfilled");

endmodule
